>>> rtl/tksi_pkg.sv
`timescale 1ns / 1ps

package tksi_pkg;

    localparam logic [15:0] CK_BASE         = 16'h46EB;
    localparam int          CK_ENTRY_OFFSET = 3;
    localparam logic [15:0] CK_COUNT_W      = 16'd13;
    localparam logic [15:0] CK_FLO_W        = 16'd14;
    localparam logic [15:0] CK_FHI_W        = 16'd15;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_FIN
    } tksi_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // take the input transaction, insert, reset checksum walk
        logic step;     // add one weighted entry to the checksum
        logic publish;  // finish checksum and load the result register
    } tksi_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last;     // current walk step covers the final entry
        logic out_busy; // result register holds a transaction not yet taken
    } tksi_sts_t;

endpackage

>>> rtl/tksi_ctrl.sv
`timescale 1ns / 1ps

module tksi_ctrl
    import tksi_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  tksi_sts_t sts,
    output tksi_cmd_t cmd
);

    tksi_state_t state_reg;
    tksi_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd.load    = 1'b0;
        cmd.step    = 1'b0;
        cmd.publish = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                cmd.step = 1'b1;
                if (sts.last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!sts.out_busy) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> !sts.out_busy)
        else $error("result register overwritten while pending");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.step, cmd.publish}))
        else $error("more than one datapath command at once");

    a_fin_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && sts.last) |=> (state_reg == ST_FIN))
        else $error("checksum walk did not end in finish state");

endmodule

>>> rtl/tksi_dp.sv
`timescale 1ns / 1ps

module tksi_dp
    import tksi_pkg::*;
#(
    parameter int TABLE_DEPTH = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] s_score,
    input  logic [31:0] s_frames,
    input  logic        m_ready,
    output logic        m_valid,
    output logic [3:0]  m_rank,
    output logic [15:0] m_record_checksum,
    output logic [15:0] m_event_count,
    output logic [31:0] m_frame_total,
    input  tksi_cmd_t   cmd,
    output tksi_sts_t   sts
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int POS_W = $clog2(TABLE_DEPTH + 1);
    localparam int WGT_W = $clog2(TABLE_DEPTH + CK_ENTRY_OFFSET);

    logic [15:0]      tbl_reg  [TABLE_DEPTH];
    logic [15:0]      tbl_next [TABLE_DEPTH];
    logic [15:0]      cnt_reg;
    logic [31:0]      tot_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [15:0]      acc_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [WGT_W-1:0] wgt_reg;

    logic             out_valid_reg;
    logic [3:0]       out_rank_reg;
    logic [15:0]      out_ck_reg;
    logic [15:0]      out_cnt_reg;
    logic [31:0]      out_tot_reg;

    logic [TABLE_DEPTH-1:0] lt;
    logic [15:0]      tbl_sel;
    logic [15:0]      prod;
    logic [15:0]      acc_fin;
    logic             sorted;

    // entries strictly below the new score; the table is kept sorted, so the
    // set bits form a run at the bottom and its lowest index is the slot
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            lt[i] = (tbl_reg[i] < s_score);
        end
        pos_next = POS_W'(TABLE_DEPTH);
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (lt[i]) begin
                pos_next = POS_W'(i);
            end
        end
    end

    always_comb begin
        tbl_next[0] = (pos_next == '0) ? s_score : tbl_reg[0];
        for (int i = 1; i < TABLE_DEPTH; i++) begin
            if (i < int'(pos_next)) begin
                tbl_next[i] = tbl_reg[i];
            end else if (i == int'(pos_next)) begin
                tbl_next[i] = s_score;
            end else begin
                tbl_next[i] = tbl_reg[i-1];
            end
        end
    end

    assign tbl_sel = tbl_reg[idx_reg];
    assign prod    = tbl_sel * 16'(wgt_reg);
    assign acc_fin = acc_reg + cnt_reg * CK_COUNT_W + tot_reg[15:0] * CK_FLO_W
                   + tot_reg[31:16] * CK_FHI_W;

    assign sts.last     = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign sts.out_busy = out_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                tbl_reg[i] <= '0;
            end
            cnt_reg <= '0;
            tot_reg <= '0;
        end else if (cmd.load) begin
            tbl_reg <= tbl_next;
            cnt_reg <= cnt_reg + 16'd1;
            tot_reg <= tot_reg + s_frames;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pos_reg <= pos_next;
            acc_reg <= CK_BASE;
            idx_reg <= '0;
            wgt_reg <= WGT_W'(CK_ENTRY_OFFSET);
        end else if (cmd.step) begin
            acc_reg <= acc_reg + prod;
            idx_reg <= sts.last ? idx_reg : idx_reg + 1'b1;
            wgt_reg <= wgt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.publish) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            out_rank_reg <= 4'(pos_reg);
            out_ck_reg   <= acc_fin;
            out_cnt_reg  <= cnt_reg;
            out_tot_reg  <= tot_reg;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_rank            = out_rank_reg;
    assign m_record_checksum = out_ck_reg;
    assign m_event_count     = out_cnt_reg;
    assign m_frame_total     = out_tot_reg;

    always_comb begin
        sorted = 1'b1;
        for (int i = 1; i < TABLE_DEPTH; i++) begin
            if (tbl_reg[i] > tbl_reg[i-1]) begin
                sorted = 1'b0;
            end
        end
    end

    a_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        sorted)
        else $error("score table lost descending order");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (cnt_reg == $past(cnt_reg) + 16'd1))
        else $error("event count did not advance on insert");

    a_rank_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (pos_reg <= POS_W'(TABLE_DEPTH)))
        else $error("insert slot beyond table depth");

endmodule

>>> rtl/top_k_score_table_insert.sv
`timescale 1ns / 1ps

// Top-k score table: keeps the TABLE_DEPTH best scores in descending order,
// a wrapping 16-bit event count and a wrapping 32-bit frame total.
// Input channel (s_*): one transaction carries a score and a frame count.
// The score is inserted below every entry greater or equal to it; the last
// entry drops off. Count and frame total advance on every transaction.
// Result channel (m_*): one transaction per input with the slot taken
// (TABLE_DEPTH means not placed), a weighted checksum over the updated
// record, the new event count and the new frame total.
// The input is accepted only while idle, so a new transaction is taken only
// after the previous result has been published, at the end of the checksum
// walk, which adds one weighted table entry per cycle through a single
// multiplier.
// A stalled receiver holds the result in the output register; the next input
// is still accepted and worked on, and only waits at the end of its checksum
// walk until the previous result has been taken.
// Reset (aresetn, synchronous, active low) clears the table, the count, the
// frame total and any pending result.
module top_k_score_table_insert
    import tksi_pkg::*;
#(
    parameter int TABLE_DEPTH = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_score,
    input  logic [31:0] s_frames,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_rank,
    output logic [15:0] m_record_checksum,
    output logic [15:0] m_event_count,
    output logic [31:0] m_frame_total
);

    tksi_cmd_t cmd;
    tksi_sts_t sts;

    tksi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tksi_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_score           (s_score),
        .s_frames          (s_frames),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .m_rank            (m_rank),
        .m_record_checksum (m_record_checksum),
        .m_event_count     (m_event_count),
        .m_frame_total     (m_frame_total),
        .cmd               (cmd),
        .sts               (sts)
    );

endmodule

>>> bench/tb_top_k_score_table_insert.sv
`timescale 1ns / 1ps

module tb_top_k_score_table_insert;
    import tksi_pkg::*;

    localparam int TABLE_DEPTH = 10;
    localparam int WALK_CYCLES = TABLE_DEPTH + 2;
    localparam int RANDOM_ITEMS = 580;

    typedef struct {
        logic [3:0]  rank;
        logic [15:0] checksum;
        logic [15:0] count;
        logic [31:0] total;
    } rank_result_t;

    // Tracks the ranked table and running totals; queues the results the block owes.
    class top_k_tracker;
        logic [15:0]  best_scores [TABLE_DEPTH];
        logic [15:0]  submit_cnt;
        logic [31:0]  frame_sum;
        rank_result_t owed_results[$];
        int           mismatches;

        function new();
            foreach (best_scores[i]) best_scores[i] = '0;
            submit_cnt = '0;
            frame_sum  = '0;
            mismatches = 0;
        endfunction

        function void note_submission(logic [15:0] score, logic [31:0] frames);
            int           slot;
            logic [15:0]  sum;
            rank_result_t res;
            slot = TABLE_DEPTH;
            // ties stay above the new score: only strictly smaller entries move
            while (slot > 0 && best_scores[slot-1] < score) begin
                slot--;
                if (slot + 1 < TABLE_DEPTH)
                    best_scores[slot+1] = best_scores[slot];
            end
            if (slot < TABLE_DEPTH)
                best_scores[slot] = score;
            submit_cnt = submit_cnt + 16'd1;
            frame_sum  = frame_sum + frames;
            sum = CK_BASE;
            for (int i = 0; i < TABLE_DEPTH; i++)
                sum = sum + 16'(32'(best_scores[i]) * (i + CK_ENTRY_OFFSET));
            sum = sum + submit_cnt * CK_COUNT_W;
            sum = sum + frame_sum[15:0] * CK_FLO_W;
            sum = sum + frame_sum[31:16] * CK_FHI_W;
            res.rank     = 4'(slot);
            res.checksum = sum;
            res.count    = submit_cnt;
            res.total    = frame_sum;
            owed_results.push_back(res);
        endfunction

        function void check_result(logic [3:0] rank, logic [15:0] checksum,
                                   logic [15:0] count, logic [31:0] total);
            rank_result_t exp_res;
            if (owed_results.size() == 0) begin
                $error("result transaction with nothing pending: rank=%0d checksum=%h",
                       rank, checksum);
                mismatches++;
                return;
            end
            exp_res = owed_results.pop_front();
            if (rank !== exp_res.rank) begin
                $error("rank: expected %0d, actual %0d", exp_res.rank, rank);
                mismatches++;
            end
            if (checksum !== exp_res.checksum) begin
                $error("record_checksum: expected %h, actual %h", exp_res.checksum, checksum);
                mismatches++;
            end
            if (count !== exp_res.count) begin
                $error("event_count: expected %0d, actual %0d", exp_res.count, count);
                mismatches++;
            end
            if (total !== exp_res.total) begin
                $error("frame_total: expected %h, actual %h", exp_res.total, total);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_score;
    logic [31:0] s_frames;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_rank;
    logic [15:0] m_record_checksum;
    logic [15:0] m_event_count;
    logic [31:0] m_frame_total;

    top_k_tracker tracker = new();

    top_k_score_table_insert #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_score           (s_score),
        .s_frames          (s_frames),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_rank            (m_rank),
        .m_record_checksum (m_record_checksum),
        .m_event_count     (m_event_count),
        .m_frame_total     (m_frame_total)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Offer one transaction, optionally after random idle cycles; returns once accepted.
    task automatic send_score(input logic [15:0] score, input logic [31:0] frames,
                              input bit may_idle);
        while (may_idle && $urandom_range(0, 99) < 13) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_score  <= score;
        s_frames <= frames;
        do @(posedge aclk); while (!s_ready);
        tracker.note_submission(score, frames);
    endtask

    function automatic logic [15:0] pick_score();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'($urandom);
            4, 5:       return tracker.best_scores[$urandom_range(0, TABLE_DEPTH - 1)];
            6:          return tracker.best_scores[TABLE_DEPTH-1] + 16'($urandom_range(0, 2));
            7:          return 16'hFFFF - 16'($urandom_range(0, 15));
            8:          return 16'($urandom_range(0, 15));
            default:    return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_frames();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return 32'($urandom_range(0, 1000));
            2:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 1000));
            default: return 32'h0;
        endcase
    endfunction

    // result side: random stalls, one long hold-off, and a stretch with none
    initial begin
        int results_seen;
        int holdoff_left;
        bit holdoff_done;
        results_seen = 0;
        holdoff_left = 0;
        holdoff_done = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                tracker.check_result(m_rank, m_record_checksum, m_event_count, m_frame_total);
                results_seen++;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
            end else if (!holdoff_done && results_seen == 60) begin
                holdoff_done = 1'b1;
                holdoff_left = 300;
            end
            if (holdoff_left > 0)
                m_ready <= 1'b0;
            else if (results_seen >= 150 && results_seen < 300)
                m_ready <= 1'b1;
            else
                m_ready <= ($urandom_range(0, 99) >= 13);
        end
    end

    initial begin
        s_valid  <= 1'b0;
        s_score  <= '0;
        s_frames <= '0;
        aresetn  <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, ties, frame total wrap, full table behavior
        send_score(16'h0000, 32'h0000_0000, 1'b0);
        send_score(16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        send_score(16'hFFFF, 32'h0000_0001, 1'b0);
        send_score(16'h0001, 32'hFFFF_FFFF, 1'b0);
        send_score(16'h8000, 32'hAAAA_AAAA, 1'b1);
        send_score(16'h5555, 32'h5555_5555, 1'b1);
        send_score(16'hAAAA, 32'h8000_0000, 1'b0);
        send_score(16'h8000, 32'h0000_FFFF, 1'b1);
        send_score(16'h7FFF, 32'hFFFF_0000, 1'b0);
        send_score(16'h0002, 32'h0000_0007, 1'b1);
        send_score(16'h0001, 32'h0000_0003, 1'b0);
        send_score(16'h0001, 32'h0000_0000, 1'b0);
        // table full now: tie with the last entry is not placed
        send_score(tracker.best_scores[TABLE_DEPTH-1], 32'hFFFF_FFFF, 1'b0);
        send_score(tracker.best_scores[TABLE_DEPTH-1] + 16'd1, 32'h1234_5678, 1'b1);
        send_score(16'h0000, 32'hFFFF_FFFF, 1'b0);
        send_score(16'hFFFF, 32'h0000_0000, 1'b0);
        send_score(16'hFFFE, 32'hFFFF_FFFF, 1'b1);
        send_score(16'h8000, 32'h7FFF_FFFF, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_score(pick_score(), pick_frames(), !(i >= 250 && i < 400));

        s_valid <= 1'b0;
        while (tracker.owed_results.size() != 0) @(posedge aclk);
        repeat (2 * WALK_CYCLES) @(posedge aclk);

        if (tracker.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
